@@ design/scc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned BIT_W   = 5;
    localparam logic [BIT_W-1:0] BIT_LAST = 5'd31;
    localparam logic [4:0] DEC_BASE = 5'd10;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_DP    = 8'h80;

    // floor(x / 10) = (x * DIV10_RECIP) >> DIV10_SH, exact for any 32-bit x
    localparam logic [VAL_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int unsigned      DIV10_SH    = 35;

    typedef enum logic [2:0] {
        CMD_SCAN      = 3'd0,
        CMD_WR_SEG    = 3'd1,
        CMD_WR_DIGIT  = 3'd2,
        CMD_WR_DP     = 3'd3,
        CMD_CLEAR     = 3'd4,
        CMD_VAL_BLANK = 3'd5,
        CMD_VAL_ZEROS = 3'd6
    } t_cmd;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic digit_commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic value_go;
        logic out_busy;
        logic last_digit;
    } t_dp_status;

    // common cathode, bit 0 = a ... bit 6 = g
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'h3F;
            4'd1: s = 8'h06;
            4'd2: s = 8'h5B;
            4'd3: s = 8'h4F;
            4'd4: s = 8'h66;
            4'd5: s = 8'h6D;
            4'd6: s = 8'h7D;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7F;
            4'd9: s = 8'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // 10^(cnt-1) wrapped to 32 bits, 1 for a count of zero
    function automatic logic [VAL_W-1:0] pow10_of(input logic [3:0] cnt);
        logic [VAL_W-1:0] p;
        case (cnt)
            4'd0:  p = 32'd1;
            4'd1:  p = 32'd1;
            4'd2:  p = 32'd10;
            4'd3:  p = 32'd100;
            4'd4:  p = 32'd1000;
            4'd5:  p = 32'd10000;
            4'd6:  p = 32'd100000;
            4'd7:  p = 32'd1000000;
            4'd8:  p = 32'd10000000;
            4'd9:  p = 32'd100000000;
            4'd10: p = 32'd1000000000;
            4'd11: p = 32'd1410065408;
            4'd12: p = 32'd1215752192;
            4'd13: p = 32'd3567587328;
            4'd14: p = 32'd1316134912;
            4'd15: p = 32'd276447232;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

@@ design/seven_segment_scan_controller.sv @@
// multiplexed seven-segment display controller, buffer and scan logic
// input channel: one command beat per accepted item (scan tick, segment or
//   digit write, clear, or decimal value write); output channel: exactly one
//   result beat per command, is_scan/seg_out/digit_sel, zero for non-scan
// a result beat is registered and shows up the cycle after its command beat
// scan, segment, digit and clear commands are done in their accept cycle, so they can
//   stream at one beat per clock as long as the result side keeps up
// a value write converts one decimal digit at a time (32 steps of a
//   shared bit-serial divider plus one buffer write), so it holds the input
//   stalled until all its digits, at most eight, are written; its result
//   beat still leaves right away, the stall only keeps the next command out
// a scan tick gives the buffered byte of the current digit, then a blank
//   frame for the same digit, then moves to the next digit
// reset blanks the whole buffer, points the scan at digit 0 and empties the
//   result register; no clearing pass is needed
// when the receiver stalls, the result beat holds and one more command is
//   refused until that beat is taken
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_scan_controller #(
    parameter int NUM_DIGITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire [2:0]   i_cmd,
    input  wire [3:0]   i_position,
    input  wire [7:0]   i_seg_code,
    input  wire [3:0]   i_digit_value,
    input  wire [31:0]  i_number,
    input  wire [3:0]   i_digit_count,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_is_scan,
    output logic [7:0]  o_seg_out,
    output logic [2:0]  o_digit_sel
);
    import scc_pkg::*;

    t_ctrl_cmd  ctl_cmd;
    t_dp_status dp_status;

    // sequencer for accept and the per-digit conversion loop
    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (ctl_cmd)
    );

    // buffer, scan pointer, divider and result register
    scc_datapath #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_position    (i_position),
        .i_seg_code    (i_seg_code),
        .i_digit_value (i_digit_value),
        .i_number      (i_number),
        .i_digit_count (i_digit_count),
        .i_out_stall   (i_out_stall),
        .i_cmd_ctl     (ctl_cmd),
        .o_status      (dp_status),
        .o_out_valid   (o_out_valid),
        .o_is_scan     (o_is_scan),
        .o_seg_out     (o_seg_out),
        .o_digit_sel   (o_digit_sel)
    );

endmodule
`default_nettype wire

@@ design/scc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  scc_pkg::t_dp_status i_status,
    output scc_pkg::t_ctrl_cmd  o_cmd
);
    import scc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV   = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             accept;

    assign accept     = i_in_valid && (r_state == S_IDLE) && !i_status.out_busy;
    assign o_in_stall = (r_state != S_IDLE) || i_status.out_busy;

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = accept;
                if (accept && i_status.value_go) begin
                    n_state = S_DIV;
                    n_bit   = '0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit = r_bit + 1'b1;
                if (r_bit == BIT_LAST) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.digit_commit = 1'b1;
                n_bit = '0;
                if (i_status.last_digit) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

endmodule
`default_nettype wire

@@ design/scc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scc_datapath #(
    parameter int NUM_DIGITS = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire [2:0]           i_cmd,
    input  wire [3:0]           i_position,
    input  wire [7:0]           i_seg_code,
    input  wire [3:0]           i_digit_value,
    input  wire [31:0]          i_number,
    input  wire [3:0]           i_digit_count,
    input  wire                 i_out_stall,
    input  scc_pkg::t_ctrl_cmd  i_cmd_ctl,
    output scc_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output logic                o_is_scan,
    output logic [7:0]          o_seg_out,
    output logic [2:0]          o_digit_sel
);
    import scc_pkg::*;

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [3:0] NUM_D4 = 4'(NUM_DIGITS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_DIGITS - 1);

    logic [7:0]       r_buf [NUM_DIGITS];
    logic [IDX_W-1:0] r_scan;
    logic             r_blank_ph;
    logic             r_out_valid, r_is_scan;
    logic [7:0]       r_seg_out;
    logic [2:0]       r_digit_sel;

    // value conversion state
    logic [VAL_W-1:0] r_value, r_div, r_rem, r_dvd;
    logic [3:0]       r_m10, r_left;
    logic [IDX_W-1:0] r_wpos;
    logic             r_blank_md, r_lead;

    t_cmd             cmd;
    logic             pos_ok;
    logic [3:0]       avail, len_cut;
    logic [VAL_W-1:0] pow_in;

    // one restoring division step plus a mod-10 fold of the quotient
    logic [VAL_W:0]   rem_sh;
    logic             ge;
    logic [VAL_W-1:0] rem_nx;
    logic [4:0]       m2;
    logic [3:0]       m10_nx;

    // divisor for the next digit
    logic [2*VAL_W-1:0] div_prod;
    logic [VAL_W-1:0]   div_next;

    logic [3:0]       dig;
    logic             lead_nx;
    logic [7:0]       dig_seg;

    assign cmd     = t_cmd'(i_cmd);
    assign pos_ok  = i_position < NUM_D4;
    assign avail   = NUM_D4 - i_position;
    assign len_cut = (i_digit_count < avail) ? i_digit_count : avail;
    assign pow_in  = pow10_of(i_digit_count);

    assign o_status.value_go   = ((cmd == CMD_VAL_BLANK) || (cmd == CMD_VAL_ZEROS))
                                 && pos_ok && (len_cut != 4'd0);
    assign o_status.out_busy   = r_out_valid && i_out_stall;
    assign o_status.last_digit = (r_left == 4'd1);

    always_comb begin
        rem_sh = {r_rem, r_dvd[VAL_W-1]};
        ge     = rem_sh >= {1'b0, r_div};
        rem_nx = ge ? VAL_W'(rem_sh - {1'b0, r_div}) : rem_sh[VAL_W-1:0];
        m2     = {r_m10, ge};
        m10_nx = (m2 >= DEC_BASE) ? 4'(m2 - DEC_BASE) : m2[3:0];
    end

    always_comb begin
        div_prod = (2*VAL_W)'(r_div) * (2*VAL_W)'(DIV10_RECIP);
        div_next = VAL_W'(div_prod >> DIV10_SH);
    end

    always_comb begin
        dig     = (r_div == '0) ? 4'd0 : r_m10;
        lead_nx = r_lead && (dig == 4'd0) && !o_status.last_digit;
        dig_seg = (r_blank_md && lead_nx) ? SEG_BLANK : seg_of(dig);
    end

    // display buffer and scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_buf[k] <= SEG_BLANK;
            end
            r_scan     <= '0;
            r_blank_ph <= 1'b0;
        end else if (i_cmd_ctl.accept) begin
            case (cmd)
                CMD_SCAN: begin
                    r_blank_ph <= !r_blank_ph;
                    if (r_blank_ph) begin
                        r_scan <= (r_scan == IDX_LAST) ? '0 : r_scan + 1'b1;
                    end
                end
                CMD_WR_SEG: begin
                    if (pos_ok) r_buf[i_position[IDX_W-1:0]] <= i_seg_code;
                end
                CMD_WR_DIGIT: begin
                    if (pos_ok) r_buf[i_position[IDX_W-1:0]] <= seg_of(i_digit_value);
                end
                CMD_WR_DP: begin
                    if (pos_ok) begin
                        r_buf[i_position[IDX_W-1:0]] <= seg_of(i_digit_value) | SEG_DP;
                    end
                end
                CMD_CLEAR: begin
                    for (int k = 0; k < NUM_DIGITS; k++) begin
                        r_buf[k] <= SEG_BLANK;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd_ctl.digit_commit) begin
            r_buf[r_wpos] <= dig_seg;
        end
    end

    // conversion datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept) begin
            r_value    <= i_number;
            r_div      <= pow_in;
            r_left     <= len_cut;
            r_wpos     <= i_position[IDX_W-1:0];
            r_blank_md <= (cmd == CMD_VAL_BLANK);
            r_lead     <= 1'b1;
            r_rem      <= '0;
            r_dvd      <= i_number;
            r_m10      <= '0;
        end else if (i_cmd_ctl.div_step) begin
            r_rem <= rem_nx;
            r_dvd <= {r_dvd[VAL_W-2:0], 1'b0};
            r_m10 <= m10_nx;
        end else if (i_cmd_ctl.digit_commit) begin
            r_lead <= lead_nx;
            r_wpos <= r_wpos + 1'b1;
            r_left <= r_left - 1'b1;
            r_div  <= div_next;
            r_rem  <= '0;
            r_dvd  <= r_value;
            r_m10  <= '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_ctl.accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept) begin
            if (cmd == CMD_SCAN) begin
                r_is_scan   <= 1'b1;
                r_seg_out   <= r_blank_ph ? SEG_BLANK : r_buf[r_scan];
                r_digit_sel <= 3'(r_scan);
            end else begin
                r_is_scan   <= 1'b0;
                r_seg_out   <= SEG_BLANK;
                r_digit_sel <= 3'd0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_scan   = r_is_scan;
    assign o_seg_out   = r_seg_out;
    assign o_digit_sel = r_digit_sel;

endmodule
`default_nettype wire

@@ verif/tb_seven_segment_scan_controller.sv @@
`timescale 1ns / 1ps
module tb_seven_segment_scan_controller;
    import scc_pkg::*;

    // code 7 has no meaning in the command set
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int unsigned DIGITS = 8;
    localparam int unsigned ITEM_COUNT = 1150;
    // value writes hold the input side until all their digits are written
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned WATCHDOG_NS = 3_000_000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  position;
        logic [7:0]  seg_code;
        logic [3:0]  digit_value;
        logic [31:0] number;
        logic [3:0]  digit_count;
    } t_cmd_beat;

    typedef struct packed {
        logic       is_scan;
        logic [7:0] seg;
        logic [2:0] sel;
    } t_frame;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  in_cmd = '0;
    logic [3:0]  in_position = '0;
    logic [7:0]  in_seg_code = '0;
    logic [3:0]  in_digit_value = '0;
    logic [31:0] in_number = '0;
    logic [3:0]  in_digit_count = '0;

    // result channel
    logic       o_out_valid;
    logic       out_stall = 1'b0;
    logic       o_is_scan;
    logic [7:0] o_seg_out;
    logic [2:0] o_digit_sel;

    // commands waiting to be driven, frames waiting to be seen
    t_cmd_beat cmd_backlog[$];
    t_frame    frames_due[$];

    // shadow of the display state
    logic [7:0] shadow_digits [DIGITS];
    logic [2:0] shadow_scan_pos;
    logic       shadow_blank_phase;

    int unsigned mismatch_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_hold = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    seven_segment_scan_controller #(
        .NUM_DIGITS (DIGITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (in_cmd),
        .i_position    (in_position),
        .i_seg_code    (in_seg_code),
        .i_digit_value (in_digit_value),
        .i_number      (in_number),
        .i_digit_count (in_digit_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_is_scan     (o_is_scan),
        .o_seg_out     (o_seg_out),
        .o_digit_sel   (o_digit_sel)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // common cathode glyphs, anything above nine is dark
    function automatic logic [7:0] glyph_of(input logic [31:0] d);
        logic [7:0] g;
        case (d)
            32'd0: g = 8'h3F;
            32'd1: g = 8'h06;
            32'd2: g = 8'h5B;
            32'd3: g = 8'h4F;
            32'd4: g = 8'h66;
            32'd5: g = 8'h6D;
            32'd6: g = 8'h7D;
            32'd7: g = 8'h07;
            32'd8: g = 8'h7F;
            32'd9: g = 8'h6F;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

    // decimal run into the shadow buffer
    function automatic void store_decimal(input logic [31:0] num, input logic [3:0] start,
                                          input logic [3:0] cnt, input bit hide_lead);
        logic [31:0] divisor;
        logic [31:0] d;
        int unsigned len;
        bit leading;
        if (start >= DIGITS) return;
        // divisor keeps the full count and wraps at 32 bits
        divisor = 32'd1;
        for (int i = 1; i < cnt; i++) divisor = divisor * 32'd10;
        // a run past the last digit is cut, the divisor is not
        len = 32'(cnt);
        if (start + len > DIGITS) len = DIGITS - start;
        leading = 1'b1;
        for (int i = 0; i < len; i++) begin
            d = (divisor != 0) ? (num / divisor) % 32'd10 : 32'd0;
            if (hide_lead) begin
                // the last digit of the run always shows, zero too
                if (d != 0 || i == len - 1) leading = 1'b0;
                shadow_digits[start + i] = leading ? SEG_BLANK : glyph_of(d);
            end else begin
                shadow_digits[start + i] = glyph_of(d);
            end
            divisor = divisor / 32'd10;
        end
    endfunction

    // one command against the shadow state, returns the frame it should give
    function automatic t_frame apply_command(input t_cmd_beat b);
        t_frame f;
        f = '0;
        case (b.cmd)
            CMD_SCAN: begin
                // buffered byte first, then a dark frame, then the next digit
                f.is_scan = 1'b1;
                f.sel = shadow_scan_pos;
                f.seg = shadow_blank_phase ? SEG_BLANK : shadow_digits[shadow_scan_pos];
                if (shadow_blank_phase) begin
                    shadow_scan_pos = (shadow_scan_pos == DIGITS - 1) ? 3'd0
                                                                     : shadow_scan_pos + 3'd1;
                end
                shadow_blank_phase = ~shadow_blank_phase;
            end
            CMD_WR_SEG: begin
                if (b.position < DIGITS) shadow_digits[b.position] = b.seg_code;
            end
            CMD_WR_DIGIT: begin
                if (b.position < DIGITS)
                    shadow_digits[b.position] = glyph_of(32'(b.digit_value));
            end
            CMD_WR_DP: begin
                if (b.position < DIGITS)
                    shadow_digits[b.position] = glyph_of(32'(b.digit_value)) | SEG_DP;
            end
            CMD_CLEAR: begin
                for (int i = 0; i < DIGITS; i++) shadow_digits[i] = SEG_BLANK;
            end
            CMD_VAL_BLANK: store_decimal(b.number, b.position, b.digit_count, 1'b1);
            CMD_VAL_ZEROS: store_decimal(b.number, b.position, b.digit_count, 1'b0);
            default: ;
        endcase
        return f;
    endfunction

    function automatic void queue_cmd(input logic [2:0] cmd, input logic [3:0] pos,
                                      input logic [7:0] seg, input logic [3:0] dv,
                                      input logic [31:0] num, input logic [3:0] cnt);
        cmd_backlog.push_back('{cmd, pos, seg, dv, num, cnt});
    endfunction

    // driver: a beat goes at the edge where valid is high and stall low,
    //   the next one follows after a drawn gap; calm stretches have no gaps
    always @(posedge i_clk) begin : cmd_driver
        t_cmd_beat nxt;
        bit beat_done;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            beat_done = in_valid && !o_in_stall;
            if (beat_done) begin
                frames_due.push_back(apply_command('{in_cmd, in_position, in_seg_code,
                                                     in_digit_value, in_number,
                                                     in_digit_count}));
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 7);
            end
            // payload only moves once the current beat is gone
            if (!in_valid || beat_done) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    nxt = cmd_backlog.pop_front();
                    in_cmd <= nxt.cmd;
                    in_position <= nxt.position;
                    in_seg_code <= nxt.seg_code;
                    in_digit_value <= nxt.digit_value;
                    in_number <= nxt.number;
                    in_digit_count <= nxt.digit_count;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: holds each result for a drawn number of cycles, then checks it
    always @(posedge i_clk) begin : result_monitor
        t_frame want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            recv_hold = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (frames_due.size() == 0) begin
                    $error("result beat with nothing expected: is_scan %0d seg_out %h",
                           o_is_scan, o_seg_out);
                    mismatch_count++;
                end else begin
                    want = frames_due.pop_front();
                    if (o_is_scan !== want.is_scan) begin
                        $error("is_scan: expected %0d, got %0d", want.is_scan, o_is_scan);
                        mismatch_count++;
                    end
                    if (o_seg_out !== want.seg) begin
                        $error("seg_out: expected %h, got %h", want.seg, o_seg_out);
                        mismatch_count++;
                    end
                    if (o_digit_sel !== want.sel) begin
                        $error("digit_sel: expected %0d, got %0d", want.sel, o_digit_sel);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
                recv_hold = recv_calm ? 0 : $urandom_range(0, 7);
            end else if (o_out_valid && out_stall && recv_hold > 0) begin
                recv_hold = recv_hold - 1;
            end
            out_stall <= (recv_hold > 0);
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int unsigned counted;
        int unsigned kind;
        logic [2:0]  cmd;
        logic [3:0]  pos;
        logic [3:0]  cnt;
        logic [31:0] num;
        for (int i = 0; i < DIGITS; i++) shadow_digits[i] = SEG_BLANK;
        shadow_scan_pos = 3'd0;
        shadow_blank_phase = 1'b0;

        // directed part: extremes, every command and the odd corners
        queue_cmd(CMD_SCAN, 4'd0, 8'h00, 4'd0, 32'd0, 4'd0);           // blank buffer after reset
        queue_cmd(CMD_SCAN, 4'd15, 8'hFF, 4'd15, 32'hFFFF_FFFF, 4'd15);
        queue_cmd(CMD_WR_SEG, 4'd0, 8'hFF, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_WR_SEG, 4'd7, 8'hA5, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_WR_SEG, 4'd8, 8'h5A, 4'd0, 32'd0, 4'd0);         // position out of range
        queue_cmd(CMD_WR_SEG, 4'd15, 8'h00, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_WR_DIGIT, 4'd1, 8'h00, 4'd9, 32'd0, 4'd0);
        queue_cmd(CMD_WR_DIGIT, 4'd2, 8'h00, 4'd15, 32'd0, 4'd0);      // above nine is dark
        queue_cmd(CMD_WR_DP, 4'd3, 8'h00, 4'd10, 32'd0, 4'd0);         // dark digit with point
        queue_cmd(CMD_WR_DP, 4'd4, 8'h00, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_SCAN, 4'd0, 8'h00, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_SCAN, 4'd0, 8'h00, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_SCAN, 4'd0, 8'h00, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_VAL_BLANK, 4'd0, 8'h00, 4'd0, 32'd0, 4'd8);      // all zero, last digit shows
        queue_cmd(CMD_VAL_ZEROS, 4'd0, 8'h00, 4'd0, 32'hFFFF_FFFF, 4'd8);
        queue_cmd(CMD_VAL_BLANK, 4'd3, 8'h00, 4'd0, 32'd12345, 4'd8);  // run past the end
        queue_cmd(CMD_VAL_ZEROS, 4'd2, 8'h00, 4'd0, 32'd777, 4'd0);    // zero count
        queue_cmd(CMD_VAL_ZEROS, 4'd0, 8'h00, 4'd0, 32'hFFFF_FFFF, 4'd15); // wrapped divisor
        queue_cmd(CMD_VAL_BLANK, 4'd9, 8'h00, 4'd0, 32'd42, 4'd2);     // start out of range
        queue_cmd(CMD_VAL_BLANK, 4'd7, 8'h00, 4'd0, 32'd5, 4'd1);
        queue_cmd(CMD_UNUSED, 4'd0, 8'hFF, 4'd9, 32'd99, 4'd3);
        queue_cmd(CMD_SCAN, 4'd0, 8'h00, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_CLEAR, 4'd0, 8'h00, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_SCAN, 4'd0, 8'h00, 4'd0, 32'd0, 4'd0);
        queue_cmd(CMD_SCAN, 4'd0, 8'h00, 4'd0, 32'd0, 4'd0);

        // random part: mostly in-range writes and plenty of scans to read them back
        counted = 0;
        while (counted < ITEM_COUNT) begin
            kind = $urandom_range(0, 99);
            pos = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                              : 4'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0)
                cnt = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
            else
                cnt = 4'($urandom_range(1, 8));
            case ($urandom_range(0, 3))
                0: num = $urandom();
                1: num = $urandom_range(0, 99_999_999);
                2: num = $urandom() >> $urandom_range(0, 31);
                default: num = $urandom_range(0, 999);
            endcase
            if (kind < 36) cmd = CMD_SCAN;
            else if (kind < 46) cmd = CMD_WR_SEG;
            else if (kind < 55) cmd = CMD_WR_DIGIT;
            else if (kind < 63) cmd = CMD_WR_DP;
            else if (kind < 66) cmd = CMD_CLEAR;
            else if (kind < 69) cmd = CMD_UNUSED;
            else if (kind < 85) cmd = CMD_VAL_BLANK;
            else cmd = CMD_VAL_ZEROS;
            queue_cmd(cmd, pos, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                      num, cnt);
            if (cmd != CMD_UNUSED) counted++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then leave room for anything unexpected to show up
        while (cmd_backlog.size() != 0 || in_valid || frames_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (frames_due.size() != 0) begin
            $error("%0d expected result beats never arrived", frames_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
